@@ rtl/slpq_pkg.sv @@
// Shared types, codes and helpers for the sorted-list priority queue.
`timescale 1ns / 1ps
package slpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_BITS   = 16;
  localparam int PRIO_BITS    = 16;
  localparam int COUNT_BITS   = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_CHANGE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_POP,
    OP_CHANGE,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [VALUE_BITS-1:0] item_value;
    logic [PRIO_BITS-1:0]  item_priority;
  } req_t;

  typedef struct packed {
    op_t                   op;
    logic [VALUE_BITS-1:0] value;
    logic [PRIO_BITS-1:0]  prio;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] popped_value;
    logic [PRIO_BITS-1:0]  popped_priority;
    logic [PRIO_BITS-1:0]  old_priority;
    logic [VALUE_BITS-1:0] head_value;
    logic [PRIO_BITS-1:0]  head_priority;
    logic                  queue_empty;
    logic [COUNT_BITS-1:0] entry_count;
  } res_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_INS_FREE,
    S_LI_START,
    S_LI_HEAD,
    S_LI_WALK,
    S_LI_FIX,
    S_LI_TAIL,
    S_POP_RD,
    S_CHG_RD,
    S_DR_START,
    S_DR_WALK,
    S_DR_NEXT,
    S_DR_SEQ,
    S_DR_PRI,
    S_RPT_RD,
    S_RPT_DATA,
    S_DONE
  } state_t;

  // a precedes or equals b under the current order
  function automatic logic prec(input logic mode, input logic [PRIO_BITS-1:0] a,
                                input logic [PRIO_BITS-1:0] b);
    return mode ? (a >= b) : (a <= b);
  endfunction

endpackage

@@ rtl/sorted_list_priority_queue.sv @@
// Top level of the sorted linked-list priority queue.
`timescale 1ns / 1ps
// Usage:
//  in_*  : request beats (insert, pop head, change priority of a value).
//          A beat moves when in_valid is high and in_stall is low.
//  out_* : one result beat per request, same order; moves when out_valid
//          is high and out_stall is low. The result register holds while
//          stalled and the block keeps taking requests into its two-entry
//          request queue behind it.
//  cfg_* : order_mode write, taken whenever cfg_valid is high (cfg_ready is
//          tied high); write it only while no request is in flight.
// Operations, list length L: pop unlinks the head onto the free list;
//  insert walks from the head, one node-store read per cycle; change
//  searches up to L nodes for the value, then runs two passes that
//  record the list order and rebuild the list by re-inserting each node.
// Reset (rst, synchronous): list empty, order_mode 0, then a build pass over
//  every node chains the free list; no request is taken during it.
module sorted_list_priority_queue #(
  parameter int CAPACITY = slpq_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  slpq_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output slpq_pkg::res_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);
  import slpq_pkg::*;

  logic order_mode;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  logic init_busy;

  assign cfg_ready = 1'b1;

  // order register: 0 smaller priority first, 1 larger first
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (cfg_valid) begin
      order_mode <= cfg_data;
    end
  end

  // front end: decode and buffer requests
  slpq_front u_front (
    .clk(clk), .rst(rst), .hold(init_busy),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop));

  // back end: list sequencer and result register
  slpq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst(rst), .order_mode(order_mode), .init_busy(init_busy),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
endmodule

@@ rtl/slpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module slpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/slpq_front.sv @@
// Front end: takes request beats, decodes them, holds them in a two-entry queue.
`timescale 1ns / 1ps
module slpq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          hold,
  input  logic          in_valid,
  output logic          in_stall,
  input  slpq_pkg::req_t in_data,
  output logic          q_valid,
  output slpq_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import slpq_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.value = in_data.item_value;
    dec.prio  = in_data.item_priority;
    case (in_data.req_type)
      REQ_INSERT: dec.op = OP_INSERT;
      REQ_POP:    dec.op = OP_POP;
      REQ_CHANGE: dec.op = OP_CHANGE;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign in_stall = hold || (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end
endmodule

@@ rtl/slpq_back.sv @@
// Back end: list sequencer over the node stores, result register.
`timescale 1ns / 1ps
module slpq_back #(
  parameter int CAPACITY = slpq_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           order_mode,
  output logic           init_busy,
  input  logic           q_valid,
  input  slpq_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output slpq_pkg::res_t out_data
);
  import slpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NONE = IW'(CAPACITY);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

  state_t state, state_next;
  logic [IW-1:0] head, head_next, free, free_next, count, count_next;
  logic [IW-1:0] n_idx, n_idx_next, a_idx, a_idx_next, b_idx, b_idx_next;
  logic [IW-1:0] i_idx, i_idx_next, guard, guard_next;
  logic [IW-1:0] seq_cnt, seq_cnt_next, k_idx, k_idx_next;
  logic [PRIO_BITS-1:0]  pri_a, pri_a_next, ins_p, ins_p_next;
  logic [VALUE_BITS-1:0] cmd_val, cmd_val_next;
  logic [PRIO_BITS-1:0]  cmd_pri, cmd_pri_next;
  logic [1:0]            status, status_next;
  logic [VALUE_BITS-1:0] pv, pv_next, hv, hv_next;
  logic [PRIO_BITS-1:0]  pp, pp_next, oldp, oldp_next, hp, hp_next;
  logic pass, pass_next, from_drain, from_drain_next;
  logic out_valid_next;
  res_t out_data_next;

  // memory ports
  logic [AW-1:0]         node_raddr, seq_raddr, pri_waddr, link_waddr;
  logic                  val_we, pri_we, link_we, seq_we;
  logic [PRIO_BITS-1:0]  pri_wdata;
  logic [IW-1:0]         link_wdata;
  logic [VALUE_BITS-1:0] val_q;
  logic [PRIO_BITS-1:0]  pri_q;
  logic [IW-1:0]         link_q;
  logic [AW-1:0]         seq_q;

  slpq_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(val_we), .waddr(free[AW-1:0]), .wdata(cmd_val_next),
    .raddr(node_raddr), .rdata(val_q));
  slpq_ram #(.WIDTH(PRIO_BITS), .DEPTH(CAPACITY)) u_pri (
    .clk(clk), .we(pri_we), .waddr(pri_waddr), .wdata(pri_wdata),
    .raddr(node_raddr), .rdata(pri_q));
  slpq_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(node_raddr), .rdata(link_q));
  slpq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_seq (
    .clk(clk), .we(seq_we), .waddr(seq_cnt[AW-1:0]), .wdata(i_idx[AW-1:0]),
    .raddr(seq_raddr), .rdata(seq_q));

  assign init_busy = (state == S_INIT);
  assign q_pop     = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      head      <= NONE;
      free      <= '0;
      count     <= '0;
      i_idx     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      free      <= free_next;
      count     <= count_next;
      i_idx     <= i_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n_idx      <= n_idx_next;
    a_idx      <= a_idx_next;
    b_idx      <= b_idx_next;
    guard      <= guard_next;
    seq_cnt    <= seq_cnt_next;
    k_idx      <= k_idx_next;
    pri_a      <= pri_a_next;
    ins_p      <= ins_p_next;
    cmd_val    <= cmd_val_next;
    cmd_pri    <= cmd_pri_next;
    status     <= status_next;
    pv         <= pv_next;
    pp         <= pp_next;
    oldp       <= oldp_next;
    hv         <= hv_next;
    hp         <= hp_next;
    pass       <= pass_next;
    from_drain <= from_drain_next;
    out_data   <= out_data_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    free_next       = free;
    count_next      = count;
    n_idx_next      = n_idx;
    a_idx_next      = a_idx;
    b_idx_next      = b_idx;
    i_idx_next      = i_idx;
    guard_next      = guard;
    seq_cnt_next    = seq_cnt;
    k_idx_next      = k_idx;
    pri_a_next      = pri_a;
    ins_p_next      = ins_p;
    cmd_val_next    = cmd_val;
    cmd_pri_next    = cmd_pri;
    status_next     = status;
    pv_next         = pv;
    pp_next         = pp;
    oldp_next       = oldp;
    hv_next         = hv;
    hp_next         = hp;
    pass_next       = pass;
    from_drain_next = from_drain;
    out_valid_next  = out_valid && out_stall;
    out_data_next   = out_data;
    node_raddr      = head[AW-1:0];
    seq_raddr       = k_idx[AW-1:0];
    val_we          = 1'b0;
    pri_we          = 1'b0;
    pri_waddr       = free[AW-1:0];
    pri_wdata       = cmd_pri;
    link_we         = 1'b0;
    link_waddr      = n_idx[AW-1:0];
    link_wdata      = NONE;
    seq_we          = 1'b0;

    case (state)
      S_INIT: begin
        // i_idx doubles as the sweep counter of the free-list build
        link_we    = 1'b1;
        link_waddr = i_idx[AW-1:0];
        link_wdata = i_idx + 1'b1;
        i_idx_next = i_idx + 1'b1;
        if (i_idx == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          cmd_val_next = q_cmd.value;
          cmd_pri_next = q_cmd.prio;
          status_next  = ST_OK;
          pv_next      = '0;
          pp_next      = '0;
          oldp_next    = '0;
          case (q_cmd.op)
            OP_INSERT: begin
              if (free >= NONE) begin
                status_next = ST_FULL;
                state_next  = S_RPT_RD;
              end else begin
                val_we          = 1'b1;
                pri_we          = 1'b1;
                pri_wdata       = q_cmd.prio;
                node_raddr      = free[AW-1:0];
                n_idx_next      = free;
                ins_p_next      = q_cmd.prio;
                from_drain_next = 1'b0;
                state_next      = S_INS_FREE;
              end
            end
            OP_POP: begin
              if (head >= NONE) begin
                status_next = ST_EMPTY;
                state_next  = S_RPT_RD;
              end else begin
                state_next = S_POP_RD;
              end
            end
            OP_CHANGE: begin
              if (head >= NONE) begin
                status_next = ST_NOT_FOUND;
                state_next  = S_RPT_RD;
              end else begin
                i_idx_next = head;
                guard_next = '0;
                state_next = S_CHG_RD;
              end
            end
            default: state_next = S_RPT_RD;
          endcase
        end
      end
      S_INS_FREE: begin
        free_next  = link_q;
        count_next = count + 1'b1;
        state_next = S_LI_START;
      end
      S_LI_START: begin
        if (head >= NONE) begin
          link_we    = 1'b1;
          head_next  = n_idx;
          state_next = from_drain ? S_DR_NEXT : S_RPT_RD;
        end else begin
          state_next = S_LI_HEAD;
        end
      end
      S_LI_HEAD: begin
        pri_a_next = pri_q;
        a_idx_next = head;
        b_idx_next = link_q;
        if (prec(order_mode, ins_p, pri_q)) begin
          link_we    = 1'b1;
          link_wdata = head;
          head_next  = n_idx;
          state_next = from_drain ? S_DR_NEXT : S_RPT_RD;
        end else if (link_q >= NONE) begin
          link_we    = 1'b1;
          link_waddr = head[AW-1:0];
          link_wdata = n_idx;
          state_next = S_LI_TAIL;
        end else begin
          node_raddr = link_q[AW-1:0];
          state_next = S_LI_WALK;
        end
      end
      S_LI_WALK: begin
        // read data belongs to node b
        if (prec(order_mode, pri_a, ins_p) && prec(order_mode, ins_p, pri_q)) begin
          link_we    = 1'b1;
          link_waddr = a_idx[AW-1:0];
          link_wdata = n_idx;
          state_next = S_LI_FIX;
        end else begin
          a_idx_next = b_idx;
          pri_a_next = pri_q;
          b_idx_next = link_q;
          if (link_q >= NONE) begin
            link_we    = 1'b1;
            link_waddr = b_idx[AW-1:0];
            link_wdata = n_idx;
            state_next = S_LI_TAIL;
          end else begin
            node_raddr = link_q[AW-1:0];
          end
        end
      end
      S_LI_FIX: begin
        link_we    = 1'b1;
        link_wdata = b_idx;
        state_next = from_drain ? S_DR_NEXT : S_RPT_RD;
      end
      S_LI_TAIL: begin
        link_we    = 1'b1;
        state_next = from_drain ? S_DR_NEXT : S_RPT_RD;
      end
      S_POP_RD: begin
        pv_next    = val_q;
        pp_next    = pri_q;
        head_next  = link_q;
        link_we    = 1'b1;
        link_waddr = head[AW-1:0];
        link_wdata = free;
        free_next  = head;
        if (count != '0) begin
          count_next = count - 1'b1;
        end
        state_next = S_RPT_RD;
      end
      S_CHG_RD: begin
        node_raddr = i_idx[AW-1:0];
        if (val_q == cmd_val) begin
          oldp_next  = pri_q;
          pri_we     = 1'b1;
          pri_waddr  = i_idx[AW-1:0];
          pass_next  = 1'b0;
          state_next = S_DR_START;
        end else if (link_q >= NONE || guard == LAST) begin
          status_next = ST_NOT_FOUND;
          state_next  = S_RPT_RD;
        end else begin
          guard_next = guard + 1'b1;
          i_idx_next = link_q;
          node_raddr = link_q[AW-1:0];
        end
      end
      S_DR_START: begin
        i_idx_next   = head;
        seq_cnt_next = '0;
        state_next   = S_DR_WALK;
      end
      S_DR_WALK: begin
        // record list order, then rebuild from an empty list
        seq_we       = 1'b1;
        seq_cnt_next = seq_cnt + 1'b1;
        node_raddr   = link_q[AW-1:0];
        if (link_q >= NONE || seq_cnt == LAST) begin
          head_next  = NONE;
          k_idx_next = '0;
          state_next = S_DR_NEXT;
        end else begin
          i_idx_next = link_q;
        end
      end
      S_DR_NEXT: begin
        if (k_idx == seq_cnt) begin
          if (!pass) begin
            pass_next  = 1'b1;
            state_next = S_DR_START;
          end else begin
            state_next = S_RPT_RD;
          end
        end else begin
          k_idx_next = k_idx + 1'b1;
          state_next = S_DR_SEQ;
        end
      end
      S_DR_SEQ: begin
        n_idx_next = IW'(seq_q);
        node_raddr = seq_q;
        state_next = S_DR_PRI;
      end
      S_DR_PRI: begin
        ins_p_next      = pri_q;
        from_drain_next = 1'b1;
        state_next      = S_LI_START;
      end
      S_RPT_RD: begin
        state_next = S_RPT_DATA;
      end
      S_RPT_DATA: begin
        hv_next    = (head >= NONE) ? '0 : val_q;
        hp_next    = (head >= NONE) ? '0 : pri_q;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next                = 1'b1;
          out_data_next.status          = status;
          out_data_next.popped_value    = pv;
          out_data_next.popped_priority = pp;
          out_data_next.old_priority    = oldp;
          out_data_next.head_value      = hv;
          out_data_next.head_priority   = hp;
          out_data_next.queue_empty     = (head >= NONE);
          out_data_next.entry_count     = COUNT_BITS'(count);
          state_next                    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= NONE)
    else $error("entry count above capacity");
  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((head >= NONE) == (count == '0)))
    else $error("head pointer and entry count disagree");
  a_full_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((free >= NONE) == (count == NONE)))
    else $error("free list and entry count disagree");
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && status == ST_FULL) |-> (count == NONE))
    else $error("full status with room left");
  a_no_pop_init: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !q_pop)
    else $error("request taken during free-list build");
`endif
endmodule
